@@ rtl/core/pid_pkg.sv @@
package pid_pkg;

  localparam int DW     = 16;               // data word width
  localparam int FB     = 16;               // gain fraction bits
  localparam int GW     = 32;               // gain register width
  localparam int CFG_W  = (DW > GW) ? DW : GW;
  localparam int IDX_W  = 3;
  localparam int GAIN_SW = GW + 1;          // gain with sign after reverse action
  localparam int DIFF_W = DW + 1;           // error and measurement change
  localparam int PROD_W = GAIN_SW + DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ACC_W  = SUM_W + 1;
  localparam int INT_W  = DW + FB + 8;      // integrator word

  localparam logic signed [DW-1:0] OUT_MIN_RST = DW'(0);
  localparam logic signed [DW-1:0] OUT_MAX_RST = DW'(255);

  typedef enum logic [IDX_W-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_OUT_MIN = 3'd3,
    CFG_OUT_MAX = 3'd4,
    CFG_P_ON_M  = 3'd5,
    CFG_REVERSE = 3'd6,
    CFG_AUTO    = 3'd7
  } cfg_idx_e;

  // clamp a fixed-point value to the integer limits; upper wins if both are passed
  function automatic logic signed [INT_W-1:0] clamp_fix(
    input logic signed [ACC_W-1:0] v,
    input logic signed [DW-1:0]    lo,
    input logic signed [DW-1:0]    hi
  );
    logic signed [ACC_W-1:0] hi_f;
    logic signed [ACC_W-1:0] lo_f;
    logic signed [ACC_W-1:0] r;
    hi_f = ACC_W'(hi) <<< FB;
    lo_f = ACC_W'(lo) <<< FB;
    priority if (v > hi_f) begin
      r = hi_f;
    end else if (v < lo_f) begin
      r = lo_f;
    end else begin
      r = v;
    end
    return r[INT_W-1:0];
  endfunction

endpackage

@@ rtl/core/pid_if.sv @@
interface pid_in_if import pid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] measurement;
  logic signed [DW-1:0] setpoint;
  logic signed [DW-1:0] manual_output;

  modport source (output valid, measurement, setpoint, manual_output, input ready);
  modport sink   (input valid, measurement, setpoint, manual_output, output ready);
endinterface

interface pid_out_if import pid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive;
  logic                 computed;

  modport source (output valid, drive, computed, input ready);
  modport sink   (input valid, drive, computed, output ready);
endinterface

@@ rtl/core/pid_controller_step.sv @@
// PID controller, one sample per word. A new sample is taken every clock
// cycle unless stalled, and its drive word passes through the input,
// multiply, sum, integrator and output stages; backpressure on the output
// stalls the stages only as far as they are full. The sustained rate of one
// word per cycle is set by the integrator update, an add and clamp loop in
// the fourth stage. Gains are unsigned Q16.16, the integrator and the output
// sum are clamped to [out_min, out_max] and drive is the clamped sum floored
// to an integer. In manual mode manual_output passes through with computed
// low; the first automatic sample seeds the integrator from manual_output.
// Write the configuration only while no word is in flight.
module pid_controller_step import pid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  pid_in_if.sink                 in_i,
  pid_out_if.source              out_o
);

  typedef struct packed {
    logic                     auto_en;
    logic                     entry;
    logic signed [DIFF_W-1:0] err;
    logic signed [DIFF_W-1:0] dmeas;
    logic signed [DW-1:0]     man;
  } s1_t;

  typedef struct packed {
    logic                     auto_en;
    logic                     entry;
    logic signed [PROD_W-1:0] ki_err;
    logic signed [PROD_W-1:0] kp_dmeas;
    logic signed [PROD_W-1:0] kp_err;
    logic signed [PROD_W-1:0] kd_dmeas;
    logic signed [DW-1:0]     man;
  } s2_t;

  typedef struct packed {
    logic                    auto_en;
    logic                    entry;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] pd;
    logic signed [DW-1:0]    man;
  } s3_t;

  typedef struct packed {
    logic                    auto_en;
    logic signed [SUM_W-1:0] pd;
    logic signed [DW-1:0]    man;
  } s4_t;

  // configuration
  logic [GW-1:0]        kp_q, ki_q, kd_q;
  logic signed [DW-1:0] out_min_q, out_max_q;
  logic                 pom_q, rev_q, auto_q;
  logic                 reclamp_q;

  // state
  logic signed [INT_W-1:0] integ_q;
  logic signed [DW-1:0]    prev_q;
  logic                    was_auto_q;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  logic signed [DW-1:0] drive_q, drive_d;
  logic                 computed_q;

  logic adv1, adv2, adv3, adv4, adv5;
  logic ld1, ld2, ld3, ld4, ld5;

  assign adv5 = !v5_q || out_o.ready;
  assign ld5  = v4_q && adv5;
  assign adv4 = !v4_q || ld5;
  assign ld4  = v3_q && adv4;
  assign adv3 = !v3_q || ld4;
  assign ld3  = v2_q && adv3;
  assign adv2 = !v2_q || ld3;
  assign ld2  = v1_q && adv2;
  assign adv1 = !v1_q || ld2;
  assign ld1  = in_i.valid && adv1;

  assign in_i.ready     = adv1;
  assign out_o.valid    = v5_q;
  assign out_o.drive    = drive_q;
  assign out_o.computed = computed_q;

  // ---------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      out_min_q <= OUT_MIN_RST;
      out_max_q <= OUT_MAX_RST;
      pom_q     <= 1'b0;
      rev_q     <= 1'b0;
      auto_q    <= 1'b0;
      reclamp_q <= 1'b0;
    end else begin
      reclamp_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_KP:      kp_q <= cfg_data_i[GW-1:0];
          CFG_KI:      ki_q <= cfg_data_i[GW-1:0];
          CFG_KD:      kd_q <= cfg_data_i[GW-1:0];
          CFG_OUT_MIN: begin
            out_min_q <= cfg_data_i[DW-1:0];
            reclamp_q <= was_auto_q;
          end
          CFG_OUT_MAX: begin
            out_max_q <= cfg_data_i[DW-1:0];
            reclamp_q <= was_auto_q;
          end
          CFG_P_ON_M:  pom_q  <= cfg_data_i[0];
          CFG_REVERSE: rev_q  <= cfg_data_i[0];
          CFG_AUTO:    auto_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- stage 1: input, error and measurement change
  logic signed [DW-1:0] prev_use;

  always_comb begin
    s1_d.auto_en = auto_q;
    s1_d.entry   = auto_q && !was_auto_q;
    // on entry the last measurement is this one, so the change is zero
    prev_use     = s1_d.entry ? in_i.measurement : prev_q;
    s1_d.err     = DIFF_W'(in_i.setpoint) - DIFF_W'(in_i.measurement);
    s1_d.dmeas   = DIFF_W'(in_i.measurement) - DIFF_W'(prev_use);
    s1_d.man     = in_i.manual_output;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_auto_q <= 1'b0;
      prev_q     <= '0;
    end else if (ld1) begin
      was_auto_q <= auto_q;
      if (auto_q) begin
        prev_q <= in_i.measurement;
      end
    end
  end

  // ---------------- stage 2: gain products
  logic signed [GAIN_SW-1:0] kp_s, ki_s, kd_s;

  always_comb begin
    kp_s = rev_q ? -$signed({1'b0, kp_q}) : $signed({1'b0, kp_q});
    ki_s = rev_q ? -$signed({1'b0, ki_q}) : $signed({1'b0, ki_q});
    kd_s = rev_q ? -$signed({1'b0, kd_q}) : $signed({1'b0, kd_q});
    s2_d.auto_en  = s1_q.auto_en;
    s2_d.entry    = s1_q.entry;
    s2_d.ki_err   = ki_s * s1_q.err;
    s2_d.kp_dmeas = kp_s * s1_q.dmeas;
    s2_d.kp_err   = kp_s * s1_q.err;
    s2_d.kd_dmeas = kd_s * s1_q.dmeas;
    s2_d.man      = s1_q.man;
  end

  // ---------------- stage 3: integrator step and P minus D
  always_comb begin
    s3_d.auto_en = s2_q.auto_en;
    s3_d.entry   = s2_q.entry;
    s3_d.delta   = SUM_W'(s2_q.ki_err) - (pom_q ? SUM_W'(s2_q.kp_dmeas) : SUM_W'(0));
    s3_d.pd      = (pom_q ? SUM_W'(0) : SUM_W'(s2_q.kp_err)) - SUM_W'(s2_q.kd_dmeas);
    s3_d.man     = s2_q.man;
  end

  // ---------------- stage 4: integrator update
  logic signed [INT_W-1:0] integ_base, integ_nxt;

  always_comb begin
    integ_base = s3_q.entry ? clamp_fix(ACC_W'(s3_q.man) <<< FB, out_min_q, out_max_q)
                            : integ_q;
    integ_nxt  = clamp_fix(ACC_W'(integ_base) + ACC_W'(s3_q.delta), out_min_q, out_max_q);
    s4_d.auto_en = s3_q.auto_en;
    s4_d.pd      = s3_q.pd;
    s4_d.man     = s3_q.man;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      priority if (reclamp_q) begin
        integ_q <= clamp_fix(ACC_W'(integ_q), out_min_q, out_max_q);
      end else if (ld4 && s3_q.auto_en) begin
        integ_q <= integ_nxt;
      end
    end
  end

  // ---------------- stage 5: output sum, clamp and floor
  logic signed [INT_W-1:0] acc_c;

  always_comb begin
    acc_c   = clamp_fix(ACC_W'(s4_q.pd) + ACC_W'(integ_q), out_min_q, out_max_q);
    drive_d = s4_q.auto_en ? acc_c[FB +: DW] : s4_q.man;
  end

  // ---------------- pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= ld1;
      if (adv2) v2_q <= ld2;
      if (adv3) v3_q <= ld3;
      if (adv4) v4_q <= ld4;
      if (adv5) v5_q <= ld5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) s1_q <= s1_d;
    if (ld2) s2_q <= s2_d;
    if (ld3) s3_q <= s3_d;
    if (ld4) s4_q <= s4_d;
    if (ld5) begin
      drive_q    <= drive_d;
      computed_q <= s4_q.auto_en;
    end
  end

`ifndef SYNTH
  logic in_acc, out_acc;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // input side only stalls when the output word is held
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  // word in, none out: occupancy grows by one
  a_occ_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=>
      ($countones({v1_q, v2_q, v3_q, v4_q, v5_q}) ==
       $past($countones({v1_q, v2_q, v3_q, v4_q, v5_q})) + 1))
    else $error("word lost entering pipeline");

  // word out, none in: occupancy shrinks by one
  a_occ_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_acc) |=>
      ($countones({v1_q, v2_q, v3_q, v4_q, v5_q}) ==
       $past($countones({v1_q, v2_q, v3_q, v4_q, v5_q})) - 1))
    else $error("word lost or duplicated in pipeline");
`endif

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pid_pkg::*;

  typedef struct {
    logic signed [DW-1:0] measurement;
    logic signed [DW-1:0] setpoint;
    logic signed [DW-1:0] manual_output;
  } sample_t;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic                 computed;
  } drive_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic                 drv_valid = 1'b0;
  logic signed [DW-1:0] drv_meas = '0;
  logic signed [DW-1:0] drv_sp = '0;
  logic signed [DW-1:0] drv_man = '0;
  logic                 rcv_ready = 1'b0;

  pid_in_if  in_if ();
  pid_out_if out_if ();

  assign in_if.valid         = drv_valid;
  assign in_if.measurement   = drv_meas;
  assign in_if.setpoint      = drv_sp;
  assign in_if.manual_output = drv_man;
  assign out_if.ready        = rcv_ready;

  pid_controller_step DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t     sample_q[$];
  drive_word_t drive_expected_q[$];
  int          errors = 0;
  int          gap_max = 0;
  int          stall_mode = 0;

  // mirror of the controller registers and state
  logic [GW-1:0]         kp_gain = '0;
  logic [GW-1:0]         ki_gain = '0;
  logic [GW-1:0]         kd_gain = '0;
  logic signed [DW-1:0]  lim_min = OUT_MIN_RST;
  logic signed [DW-1:0]  lim_max = OUT_MAX_RST;
  logic                  p_on_meas = 1'b0;
  logic                  reverse = 1'b0;
  logic                  auto_en = 1'b0;
  logic signed [INT_W-1:0] integ_q = '0;
  logic signed [DW-1:0]  prev_meas = '0;
  logic                  was_auto = 1'b0;

  // upper limit is tested first, so it wins when both limits are exceeded
  function automatic longint limit_fix(longint v);
    longint hi;
    longint lo;
    hi = longint'(lim_max) <<< FB;
    lo = longint'(lim_min) <<< FB;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic drive_word_t pid_predict(logic signed [DW-1:0] meas,
                                              logic signed [DW-1:0] sp,
                                              logic signed [DW-1:0] man);
    drive_word_t r;
    longint kp;
    longint ki;
    longint kd;
    longint err;
    longint dmeas;
    longint integ;
    longint acc;
    if (!auto_en) begin
      was_auto   = 1'b0;
      r.drive    = man;
      r.computed = 1'b0;
      return r;
    end
    // bumpless start: seed from the manual word
    if (!was_auto) begin
      integ_q   = INT_W'(limit_fix(longint'(man) <<< FB));
      prev_meas = meas;
      was_auto  = 1'b1;
    end
    kp = longint'(kp_gain);
    ki = longint'(ki_gain);
    kd = longint'(kd_gain);
    if (reverse) begin
      kp = -kp;
      ki = -ki;
      kd = -kd;
    end
    err   = longint'(sp) - longint'(meas);
    dmeas = longint'(meas) - longint'(prev_meas);
    integ = longint'(integ_q) + ki * err;
    if (p_on_meas) integ = integ - kp * dmeas;
    integ   = limit_fix(integ);
    integ_q = INT_W'(integ);
    acc = p_on_meas ? 0 : kp * err;
    acc = limit_fix(acc + integ - kd * dmeas);
    prev_meas  = meas;
    r.drive    = DW'(acc >>> FB);
    r.computed = 1'b1;
    return r;
  endfunction

  // driver, also tracks config writes so the predictor sees them in order
  int      gap_left = 0;
  int      burst_left = 1;
  sample_t next_sample;

  always @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_idx)
        CFG_KP:      kp_gain = cfg_data[GW-1:0];
        CFG_KI:      ki_gain = cfg_data[GW-1:0];
        CFG_KD:      kd_gain = cfg_data[GW-1:0];
        CFG_OUT_MIN: begin
          lim_min = cfg_data[DW-1:0];
          if (was_auto) integ_q = INT_W'(limit_fix(longint'(integ_q)));
        end
        CFG_OUT_MAX: begin
          lim_max = cfg_data[DW-1:0];
          if (was_auto) integ_q = INT_W'(limit_fix(longint'(integ_q)));
        end
        CFG_P_ON_M:  p_on_meas = cfg_data[0];
        CFG_REVERSE: reverse = cfg_data[0];
        CFG_AUTO:    auto_en = cfg_data[0];
        default: ;
      endcase
    end
    if (drv_valid && in_if.ready)
      drive_expected_q.push_back(pid_predict(drv_meas, drv_sp, drv_man));
    if (!drv_valid || in_if.ready) begin
      if (gap_left > 0 || sample_q.size() == 0) begin
        drv_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_sample = sample_q.pop_front();
        drv_meas  <= next_sample.measurement;
        drv_sp    <= next_sample.setpoint;
        drv_man   <= next_sample.manual_output;
        drv_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int          stall_ctr = 0;
  drive_word_t want;

  always @(posedge clk) begin
    stall_ctr++;
    if (out_if.valid && rcv_ready) begin
      if (drive_expected_q.size() == 0) begin
        $error("unexpected word: drive %0d computed %0b", out_if.drive, out_if.computed);
        errors++;
      end else begin
        want = drive_expected_q.pop_front();
        if (out_if.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, out_if.drive);
          errors++;
        end
        if (out_if.computed !== want.computed) begin
          $error("computed: expected %0b, got %0b", want.computed, out_if.computed);
          errors++;
        end
      end
    end
    case (stall_mode)
      1:       rcv_ready <= ($urandom_range(0, 3) != 0);
      2:       rcv_ready <= ((stall_ctr % 11) < 7);
      3:       rcv_ready <= ((stall_ctr % 37) > 20);
      default: rcv_ready <= 1'b1;
    endcase
  end

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic add_sample(int m, int s, int o);
    sample_t x;
    x.measurement   = DW'(m);
    x.setpoint      = DW'(s);
    x.manual_output = DW'(o);
    sample_q.push_back(x);
  endtask

  // wait for the pipeline to drain
  task automatic settle();
    while (sample_q.size() != 0 || drv_valid || drive_expected_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [GW-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return GW'($urandom_range(0, 32'h0002_0000));
      4:       return GW'($urandom_range(0, 32'h0000_4000));
      default: return GW'($urandom);
    endcase
  endfunction

  initial begin
    int               ph;
    int               k;
    int               j;
    int               tmp;
    int               n;
    int               lo;
    int               hi;
    int               walk;
    int               sp_base;
    int               walk_pct;
    int               sent;
    int               order[8];
    logic [CFG_W-1:0] vals[8];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // manual passthrough at reset settings
    #1;
    add_sample(-32768, 32767, -32768);
    add_sample(32767, -32768, 32767);
    add_sample(0, 0, 0);
    add_sample(-1, 1, -1);
    settle();

    cfg_write(CFG_KP, CFG_W'(32'h0001_0000));
    cfg_write(CFG_KI, CFG_W'(32'h0000_8000));
    cfg_write(CFG_KD, CFG_W'(32'h0002_0000));
    cfg_write(CFG_OUT_MIN, CFG_W'(-1000));
    cfg_write(CFG_OUT_MAX, CFG_W'(1000));
    cfg_write(CFG_AUTO, CFG_W'(1));
    // entry to automatic, manual word above the upper limit
    #1;
    add_sample(100, 200, 32767);
    add_sample(-32768, 32767, 0);
    add_sample(32767, -32768, 0);
    add_sample(50, 50, -5);
    settle();

    // narrowing the limits in automatic clamps the integrator at once
    cfg_write(CFG_OUT_MAX, CFG_W'(100));
    cfg_write(CFG_OUT_MIN, CFG_W'(-50));
    cfg_write(CFG_P_ON_M, CFG_W'(1));
    cfg_write(CFG_REVERSE, CFG_W'(1));
    #1;
    add_sample(10, 20, 0);
    add_sample(-300, 0, 0);
    add_sample(300, 0, 0);
    settle();

    // inverted limits, largest gains
    cfg_write(CFG_OUT_MIN, CFG_W'(200));
    cfg_write(CFG_OUT_MAX, CFG_W'(-200));
    cfg_write(CFG_KP, '1);
    cfg_write(CFG_KI, '1);
    cfg_write(CFG_KD, '1);
    cfg_write(CFG_REVERSE, CFG_W'(0));
    #1;
    add_sample(0, 10, 0);
    add_sample(0, -10, 0);
    add_sample(5, 5, 5);
    settle();

    cfg_write(CFG_OUT_MIN, CFG_W'(-32768));
    cfg_write(CFG_OUT_MAX, CFG_W'(32767));
    cfg_write(CFG_P_ON_M, CFG_W'(0));
    #1;
    add_sample(-32768, 32767, 0);
    add_sample(32767, -32768, 0);
    settle();

    // back to manual, then re-entry seeds again
    cfg_write(CFG_AUTO, CFG_W'(0));
    #1;
    add_sample(1, 2, -7);
    settle();
    cfg_write(CFG_AUTO, CFG_W'(1));
    #1;
    add_sample(-32768, -32768, -32768);
    add_sample(7, 9, 32767);
    settle();

    sent = 0;
    ph = 0;
    while (sent < 790) begin
      vals[CFG_KP] = CFG_W'(rand_gain());
      vals[CFG_KI] = CFG_W'(rand_gain());
      vals[CFG_KD] = CFG_W'(rand_gain());
      case ($urandom_range(0, 5))
        0: begin
          lo = -32768;
          hi = 32767;
        end
        1: begin
          hi = int'($urandom_range(0, 4000)) - 2000;
          lo = hi + int'($urandom_range(0, 2000));
        end
        default: begin
          lo = int'($urandom_range(0, 4000)) - 2000;
          hi = lo + int'($urandom_range(1, 3000));
        end
      endcase
      vals[CFG_OUT_MIN] = {(CFG_W-DW)'($urandom), DW'(lo)};
      vals[CFG_OUT_MAX] = {(CFG_W-DW)'($urandom), DW'(hi)};
      vals[CFG_P_ON_M]  = {(CFG_W-1)'($urandom), 1'($urandom_range(0, 1))};
      vals[CFG_REVERSE] = {(CFG_W-1)'($urandom), 1'($urandom_range(0, 1))};
      vals[CFG_AUTO]    = {(CFG_W-1)'($urandom), 1'($urandom_range(0, 4) != 0)};

      for (k = 0; k < 8; k++) order[k] = k;
      for (k = 7; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < 8; k++)
        if (ph == 0 || $urandom_range(0, 3) != 0)
          cfg_write(cfg_idx_e'(order[k]), vals[order[k]]);

      case ($urandom_range(0, 3))
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 8;
        default: gap_max = 20;
      endcase
      stall_mode = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0:       walk_pct = 0;
        1:       walk_pct = 7;
        default: walk_pct = 9;
      endcase
      sp_base = int'($urandom_range(0, 4000)) - 2000;
      walk = sp_base + int'($urandom_range(0, 400)) - 200;
      n = $urandom_range(50, 90);
      #1;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < walk_pct) begin
          walk = walk + int'($urandom_range(0, 100)) - 50;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
          add_sample(walk, sp_base, int'($urandom_range(0, 6000)) - 3000);
        end else begin
          add_sample(int'($urandom), int'($urandom), int'($urandom));
        end
      end
      sent += n;
      ph++;
      settle();
    end

    if (errors == 0 && drive_expected_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pid_pkg.sv
rtl/core/pid_if.sv
rtl/core/pid_controller_step.sv
verif/tb.sv
